// File: rtl/fba_pkg.sv
package fba_pkg;

    // Frame space and bitmap geometry.
    localparam int NUM_FRAMES  = 4096;
    localparam int FRAME_W     = 12;
    localparam int WORD_BITS   = 32;
    localparam int BIT_W       = 5;
    localparam int MAP_WORDS   = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int FIELD_WORDS = (1 << FRAME_W) / WORD_BITS;
    localparam int SCAN_WORDS  = (MAP_WORDS < FIELD_WORDS) ? MAP_WORDS : FIELD_WORDS;
    localparam int CNT_W       = $clog2(SCAN_WORDS + 1);
    localparam int AW          = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    // Configuration register.
    localparam int                 LIMIT_W         = 13;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 13'd4096;
    localparam int                 APB_AW          = 3;
    localparam logic               REG_FRAME_LIMIT = 1'b0;

    // Stream payload widths.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // Request kinds.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes.
    typedef logic [2:0] status_t;
    localparam status_t STAT_ALLOCATED = 3'd0;
    localparam status_t STAT_MAPPED    = 3'd1;
    localparam status_t STAT_FULL      = 3'd2;
    localparam status_t STAT_FREED     = 3'd3;
    localparam status_t STAT_NOTHING   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ALLOC_WR,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } fba_state_t;

    // Access request from the sequencer to the bitmap memory.
    typedef struct packed {
        logic                 rd_en;
        logic [AW-1:0]        rd_addr;
        logic                 wr_en;
        logic [AW-1:0]        wr_addr;
        logic [WORD_BITS-1:0] wr_data;
    } map_req_t;

endpackage

// File: rtl/fba_map_ram.sv
module fba_map_ram (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fba_pkg::map_req_t           req,
    output logic [fba_pkg::WORD_BITS-1:0] rd_data
);
    import fba_pkg::*;

    logic [WORD_BITS-1:0] mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] valid_reg;
    logic [WORD_BITS-1:0] rd_word_reg;
    logic                 rd_valid_reg;

    // Bitmap storage; no reset, validity is tracked per word.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_word_reg <= mem[req.rd_addr];
        end
    end

    // A word never written since reset reads as all frames free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

// File: rtl/fba_bit_unit.sv
module fba_bit_unit (
    input  logic [fba_pkg::WORD_BITS-1:0] word,
    input  logic [fba_pkg::BIT_W-1:0]     bit_idx,
    input  logic                          bit_set,
    output logic                          full,
    output logic [fba_pkg::BIT_W-1:0]     first_zero,
    output logic [fba_pkg::WORD_BITS-1:0] new_word
);
    import fba_pkg::*;

    logic [WORD_BITS-1:0] mask;

    // Word full test and lowest clear bit of the current word.
    always_comb
    begin
        full       = &word;
        first_zero = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (!word[j])
            begin
                first_zero = BIT_W'(j);
            end
        end
    end

    // Set or clear one bit of the word.
    always_comb
    begin
        mask     = WORD_BITS'(1) << bit_idx;
        new_word = bit_set ? (word | mask) : (word & ~mask);
    end

endmodule

// File: rtl/fba_ctrl.sv
module fba_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [fba_pkg::LIMIT_W-1:0]   frame_limit,
    // Request stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [11:0] entry_frame, [12] kernel_page, [13] write_req, [15:14] zero
    input  logic [fba_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] action
    input  logic                          s_tuser,
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] status, [14:3] new_frame, [15] present, [16] writable,
    // [17] user_mode, [23:18] zero
    output logic [fba_pkg::M_TDATA_W-1:0] m_tdata,
    // Bitmap memory and bit unit.
    output fba_pkg::map_req_t             map_req,
    input  logic [fba_pkg::WORD_BITS-1:0] rd_data,
    input  logic                          full,
    input  logic [fba_pkg::BIT_W-1:0]     first_zero,
    input  logic [fba_pkg::WORD_BITS-1:0] new_word,
    output logic [fba_pkg::BIT_W-1:0]     bit_idx,
    output logic                          bit_set
);
    import fba_pkg::*;

    fba_state_t           state_reg, state_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;
    logic                 kern_reg, kern_next;
    logic                 wrt_reg, wrt_next;
    status_t              status_reg, status_next;
    logic [CNT_W-1:0]     words_reg, words_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                 pend_reg, pend_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [FRAME_W-1:0]       in_entry;
    logic [LIMIT_W-BIT_W-1:0] lim_words;
    logic                     is_alloc;

    assign in_entry  = s_tdata[FRAME_W-1:0];
    assign lim_words = frame_limit[LIMIT_W-1:BIT_W];
    assign is_alloc  = (status_reg == STAT_ALLOCATED);
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign bit_idx   = frame_reg[BIT_W-1:0];
    assign bit_set   = (state_reg == S_ALLOC_WR);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rd_idx_reg  <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_idx_reg  <= rd_idx_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        frame_reg   <= frame_next;
        kern_reg    <= kern_next;
        wrt_reg     <= wrt_next;
        status_reg  <= status_next;
        words_reg   <= words_next;
        chk_idx_reg <= chk_idx_next;
        m_data_reg  <= m_data_next;
    end

    // Sequencer: one bitmap word read per cycle during a search.
    always_comb
    begin
        state_next   = state_reg;
        frame_next   = frame_reg;
        kern_next    = kern_reg;
        wrt_next     = wrt_reg;
        status_next  = status_reg;
        words_next   = words_reg;
        rd_idx_next  = rd_idx_reg;
        chk_idx_next = chk_idx_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        map_req      = '0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    frame_next  = in_entry;
                    kern_next   = s_tdata[FRAME_W];
                    wrt_next    = s_tdata[FRAME_W+1];
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    if (int'(lim_words) > SCAN_WORDS)
                    begin
                        words_next = CNT_W'(SCAN_WORDS);
                    end
                    else
                    begin
                        words_next = CNT_W'(lim_words);
                    end
                    if (s_tuser == ACT_ALLOC)
                    begin
                        if (in_entry != '0)
                        begin
                            status_next = STAT_MAPPED;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else if (in_entry == '0)
                    begin
                        status_next = STAT_NOTHING;
                        state_next  = S_DONE;
                    end
                    else if (32'(in_entry) < NUM_FRAMES)
                    begin
                        state_next = S_FREE_RD;
                    end
                    else
                    begin
                        status_next = STAT_FREED;
                        state_next  = S_DONE;
                    end
                end
            end

            S_SCAN:
            begin
                if (pend_reg && !full)
                begin
                    // The word read last cycle has a clear bit.
                    frame_next = FRAME_W'({chk_idx_reg, first_zero});
                    state_next = S_ALLOC_WR;
                end
                else if (rd_idx_reg < words_reg)
                begin
                    map_req.rd_en   = 1'b1;
                    map_req.rd_addr = AW'(rd_idx_reg);
                    chk_idx_next    = rd_idx_reg;
                    rd_idx_next     = rd_idx_reg + CNT_W'(1);
                    pend_next       = 1'b1;
                end
                else
                begin
                    status_next = STAT_FULL;
                    state_next  = S_DONE;
                end
            end

            S_ALLOC_WR:
            begin
                map_req.wr_en   = 1'b1;
                map_req.wr_addr = AW'(frame_reg >> BIT_W);
                map_req.wr_data = new_word;
                status_next     = STAT_ALLOCATED;
                state_next      = S_DONE;
            end

            S_FREE_RD:
            begin
                map_req.rd_en   = 1'b1;
                map_req.rd_addr = AW'(frame_reg >> BIT_W);
                state_next      = S_FREE_WR;
            end

            S_FREE_WR:
            begin
                map_req.wr_en   = 1'b1;
                map_req.wr_addr = AW'(frame_reg >> BIT_W);
                map_req.wr_data = new_word;
                status_next     = STAT_FREED;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                // Load the result once the output register is free.
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({
                        is_alloc & ~kern_reg,
                        is_alloc & wrt_reg,
                        is_alloc,
                        (is_alloc || status_reg == STAT_MAPPED) ? frame_reg : '0,
                        status_reg});
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // An allocated frame lies inside the searched words.
    a_alloc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC_WR) |-> (CNT_W'(frame_reg >> BIT_W) < words_reg))
        else $error("allocated frame beyond search limit");

    // The frame being allocated was free in the word that was read.
    a_alloc_bit_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC_WR) |-> !rd_data[frame_reg[BIT_W-1:0]])
        else $error("allocating a frame that is already used");

    // The search never reads past its word count.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (rd_idx_reg <= words_reg))
        else $error("search index past word count");

    // A pending result waits while the output register is still held.
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && m_valid_reg && !m_tready) |=> (state_reg == S_DONE))
        else $error("result overwrote an untaken beat");

endmodule

// File: rtl/frame_bitmap_allocator.sv
// Bitmap page-frame allocator with one used bit per frame, all frames free after
// reset. An allocate request for an entry without a frame searches the bitmap
// RAM one 32-frame word per cycle through its single read port, over the first
// frame_limit / 32 words capped at 128 words, and reports full when no frame is
// free there. A free request is a read-modify-write of one word. A stalled
// result output holds the result and the block until it is taken. One request
// is in work at a time; the next beat is accepted as soon as the result has
// moved to the output register.
module frame_bitmap_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fba_pkg::APB_AW-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Request stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [11:0] entry_frame, [12] kernel_page, [13] write_req, [15:14] zero
    input  logic [fba_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] action
    input  logic                          s_tuser,
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] status, [14:3] new_frame, [15] present, [16] writable,
    // [17] user_mode, [23:18] zero
    output logic [fba_pkg::M_TDATA_W-1:0] m_tdata
);
    import fba_pkg::*;

    logic [LIMIT_W-1:0]   frame_limit_reg;
    map_req_t             map_req;
    logic [WORD_BITS-1:0] rd_data;
    logic                 full;
    logic [BIT_W-1:0]     first_zero;
    logic [WORD_BITS-1:0] new_word;
    logic [BIT_W-1:0]     bit_idx;
    logic                 bit_set;

    // Frame limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_limit_reg <= LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_FRAME_LIMIT)
        begin
            frame_limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FRAME_LIMIT) ? 32'(frame_limit_reg) : '0;

    fba_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_limit (frame_limit_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .map_req     (map_req),
        .rd_data     (rd_data),
        .full        (full),
        .first_zero  (first_zero),
        .new_word    (new_word),
        .bit_idx     (bit_idx),
        .bit_set     (bit_set)
    );

    fba_map_ram u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (map_req),
        .rd_data (rd_data)
    );

    fba_bit_unit u_bits (
        .word       (rd_data),
        .bit_idx    (bit_idx),
        .bit_set    (bit_set),
        .full       (full),
        .first_zero (first_zero),
        .new_word   (new_word)
    );

endmodule
